@@ rtl/core/ibf_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the invertible Bloom filter engine.
// Used by ibf_ctrl, ibf_dp and invertible_bloom_filter_engine_unit; no dependencies.
package ibf_pkg;

  localparam int MAX_BUCKETS = 1024;
  localparam int MAX_HASHES  = 8;
  localparam int COUNT_BITS  = 16;
  localparam int ITER_LIMIT  = 65536;

  localparam int BIDX_W  = $clog2(MAX_BUCKETS);
  localparam int SIZE_W  = $clog2(MAX_BUCKETS + 1);
  localparam int HW      = $clog2(MAX_HASHES + 1);
  localparam int HSEL_W  = $clog2(MAX_HASHES);
  localparam int ITER_W  = $clog2(ITER_LIMIT);
  localparam int NB_W    = 11;
  localparam int HC_W    = 4;
  localparam int KEY_W   = 64;
  localparam int HASH_W  = 32;
  localparam int TOT_W   = 32;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    F_INSERT = 2'd0,
    F_REMOVE = 2'd1,
    F_SUB    = 2'd2,
    F_DECODE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DECODED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_UNDEC   = 2'd3
  } status_e;

  // one bucket as stored
  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [KEY_W-1:0]      key;
    logic [HASH_W-1:0]     hsum;
  } bucket_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    crc_step;
    logic    div_start;
    logic    div_step;
    logic    h_cap;
    logic    chain_init;
    logic    idx_chk;
    logic    scan_ev;
    logic    scan_take;
    logic    scan_next;
    logic    ap_next;
    logic    mem_rd;
    logic    rd_scan;
    logic    mem_wr;
    logic    tot_inc;
    logic    out_fire;
    status_e out_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic crc_last;
    logic div_last;
    logic chain_done;
    logic want_zero;
    logic hash_match;
    logic hit;
    logic ap_last;
    logic cand;
    logic scan_last;
    logic empty;
    logic sub_ok;
  } sts_t;

  // reflected CRC-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ rtl/core/invertible_bloom_filter_engine_unit.sv @@
// Top level of the invertible Bloom filter engine: APB register file and
// the ibf_ctrl / ibf_dp pair. Depends on ibf_pkg, ibf_ctrl and ibf_dp.
//
// After reset the engine clears all 1024 buckets, one per cycle, and holds
// busy high while it does so. A transaction is taken when start is high
// and busy low; its result shows on done_o for one cycle and cannot be held
// off. Its pace is set by the byte-serial CRC-32 unit (one byte a cycle)
// and the bit-serial modulo unit: each step of the bucket index chain is a
// CRC over eight bytes and then a modulo reduction. Insert and remove hash
// the key, run s chain steps (s = h when no residue repeats, h hashes) and
// read and write each indexed bucket; subtract reads and writes one bucket,
// or answers from idle when it is out of range. Decode reads each bucket in
// turn; for a pure-looking one whose hash matches it runs the chain and the peel.
module invertible_bloom_filter_engine_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            func_i,
  input  logic [ibf_pkg::KEY_W-1:0]             key_i,
  input  logic [9:0]                            bucket_index_i,
  input  logic signed [15:0]                    remote_count_i,
  input  logic [ibf_pkg::HASH_W-1:0]            remote_hash_sum_i,
  output logic                                  done_o,
  output logic [1:0]                            status_o,
  output logic signed [1:0]                     decoded_side_o,
  output logic [ibf_pkg::KEY_W-1:0]             decoded_key_o,
  output logic [ibf_pkg::TOT_W-1:0]             remote_decoded_o,
  output logic [ibf_pkg::TOT_W-1:0]             local_decoded_o
);

  logic [ibf_pkg::NB_W-1:0] num_buckets_q;
  logic [ibf_pkg::HC_W-1:0] hash_count_q;
  ibf_pkg::cmd_t cmd;
  ibf_pkg::sts_t sts;

  // register file: address bit 2 picks the register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(hash_count_q) : 32'(num_buckets_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_buckets_q <= ibf_pkg::NB_W'(1024);
      hash_count_q  <= ibf_pkg::HC_W'(3);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) hash_count_q <= pwdata[ibf_pkg::HC_W-1:0];
      else num_buckets_q <= pwdata[ibf_pkg::NB_W-1:0];
    end
  end

  ibf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  ibf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .num_buckets_i     (num_buckets_q),
    .hash_count_i      (hash_count_q),
    .func_i            (func_i),
    .key_i             (key_i),
    .bucket_index_i    (bucket_index_i),
    .remote_count_i    (remote_count_i),
    .remote_hash_sum_i (remote_hash_sum_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .decoded_side_o    (decoded_side_o),
    .decoded_key_o     (decoded_key_o),
    .remote_decoded_o  (remote_decoded_o),
    .local_decoded_o   (local_decoded_o)
  );

endmodule

@@ rtl/core/ibf_ctrl.sv @@
// Sequencing state machine for the invertible Bloom filter engine.
// Depends on ibf_pkg; drives ibf_dp through cmd_t and reads sts_t.
module ibf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        func_i,
  input  ibf_pkg::sts_t     sts_i,
  output ibf_pkg::cmd_t     cmd_o,
  output logic              busy
);

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_HCRC  = 14'b00000000000100,
    S_HCHK  = 14'b00000000001000,
    S_CCRC  = 14'b00000000010000,
    S_CDIV  = 14'b00000000100000,
    S_CCHK  = 14'b00000001000000,
    S_HIT   = 14'b00000010000000,
    S_APRD  = 14'b00000100000000,
    S_APWR  = 14'b00001000000000,
    S_FIN   = 14'b00010000000000,
    S_SRD   = 14'b00100000000000,
    S_SEV   = 14'b01000000000000,
    S_SNEXT = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  ibf_pkg::func_e op_q, op_d;
  logic is_dec;

  assign is_dec = (op_q == ibf_pkg::F_DECODE);
  assign busy   = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.out_code = ibf_pkg::ST_DONE;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          op_d = ibf_pkg::func_e'(func_i);
          case (ibf_pkg::func_e'(func_i))
            ibf_pkg::F_INSERT, ibf_pkg::F_REMOVE: state_d = S_HCRC;
            ibf_pkg::F_SUB: begin
              if (sts_i.sub_ok) state_d = S_APRD;
              else cmd_o.out_fire = 1'b1;
            end
            ibf_pkg::F_DECODE: state_d = S_SRD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_HCRC: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.crc_last) state_d = S_HCHK;
      end
      S_HCHK: begin
        if (!is_dec) begin
          cmd_o.h_cap = 1'b1;
          cmd_o.chain_init = 1'b1;
          state_d = sts_i.want_zero ? S_FIN : S_CCRC;
        end else if (sts_i.hash_match) begin
          cmd_o.chain_init = 1'b1;
          state_d = sts_i.want_zero ? S_SNEXT : S_CCRC;
        end else begin
          state_d = S_SNEXT;
        end
      end
      S_CCRC: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.crc_last) begin
          cmd_o.div_start = 1'b1;
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_CCHK;
      end
      S_CCHK: begin
        cmd_o.idx_chk = 1'b1;
        if (sts_i.chain_done) state_d = is_dec ? S_HIT : S_APRD;
        else state_d = S_CCRC;
      end
      S_HIT: begin
        if (sts_i.hit) begin
          cmd_o.tot_inc = 1'b1;
          state_d = S_APRD;
        end else begin
          state_d = S_SNEXT;
        end
      end
      S_APRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_APWR;
      end
      S_APWR: begin
        cmd_o.mem_wr = 1'b1;
        if (sts_i.ap_last) state_d = S_FIN;
        else begin
          cmd_o.ap_next = 1'b1;
          state_d = S_APRD;
        end
      end
      S_FIN: begin
        cmd_o.out_fire = 1'b1;
        cmd_o.out_code = is_dec ? ibf_pkg::ST_DECODED : ibf_pkg::ST_DONE;
        state_d = S_IDLE;
      end
      S_SRD: begin
        cmd_o.mem_rd  = 1'b1;
        cmd_o.rd_scan = 1'b1;
        state_d = S_SEV;
      end
      S_SEV: begin
        cmd_o.scan_ev = 1'b1;
        if (sts_i.cand) begin
          cmd_o.scan_take = 1'b1;
          state_d = S_HCRC;
        end else begin
          state_d = S_SNEXT;
        end
      end
      S_SNEXT: begin
        if (sts_i.scan_last) begin
          cmd_o.out_fire = 1'b1;
          cmd_o.out_code = sts_i.empty ? ibf_pkg::ST_EMPTY : ibf_pkg::ST_UNDEC;
          state_d = S_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = S_SRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      op_q    <= ibf_pkg::F_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

@@ rtl/core/ibf_dp.sv @@
// Datapath of the invertible Bloom filter engine: bucket memory, CRC unit,
// bit-serial modulo unit, index list, scan and totals. Depends on ibf_pkg.
module ibf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ibf_pkg::cmd_t                        cmd_i,
  output ibf_pkg::sts_t                        sts_o,
  input  logic [ibf_pkg::NB_W-1:0]             num_buckets_i,
  input  logic [ibf_pkg::HC_W-1:0]             hash_count_i,
  input  logic [1:0]                           func_i,
  input  logic [ibf_pkg::KEY_W-1:0]            key_i,
  input  logic [9:0]                           bucket_index_i,
  input  logic signed [15:0]                   remote_count_i,
  input  logic [ibf_pkg::HASH_W-1:0]           remote_hash_sum_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic signed [1:0]                    decoded_side_o,
  output logic [ibf_pkg::KEY_W-1:0]            decoded_key_o,
  output logic [ibf_pkg::TOT_W-1:0]            remote_decoded_o,
  output logic [ibf_pkg::TOT_W-1:0]            local_decoded_o
);

  localparam int BW = ibf_pkg::BIDX_W;
  localparam int SW = ibf_pkg::SIZE_W;
  localparam int CB = ibf_pkg::COUNT_BITS;
  localparam int HSEL_W_L = ibf_pkg::HSEL_W;

  // effective size and hash count
  logic [SW-1:0] size_eff;
  logic [ibf_pkg::HW-1:0] want;
  logic [31:0] want_tmp;

  always_comb begin
    if (num_buckets_i == '0) size_eff = SW'(1);
    else if (32'(num_buckets_i) > 32'(ibf_pkg::MAX_BUCKETS)) size_eff = SW'(ibf_pkg::MAX_BUCKETS);
    else size_eff = SW'(num_buckets_i);
    want_tmp = 32'(hash_count_i);
    if (want_tmp > 32'(ibf_pkg::MAX_HASHES)) want_tmp = 32'(ibf_pkg::MAX_HASHES);
    if (want_tmp > 32'(size_eff)) want_tmp = 32'(size_eff);
    want = ibf_pkg::HW'(want_tmp);
  end

  // operand registers
  logic [ibf_pkg::KEY_W-1:0]  key_q;
  logic [ibf_pkg::HASH_W-1:0] h_q;
  logic [CB-1:0]              delta_q;
  logic                       plus_q;

  // CRC unit
  logic [31:0] crc_q, crc_next;
  logic [63:0] src_q;
  logic [2:0]  crc_cnt_q;
  logic        crc_short_q;

  // modulo unit
  logic [31:0]   div_b_q;
  logic [SW-1:0] rem_q;
  logic [4:0]    div_cnt_q;
  logic [SW:0]   div_t;
  logic [SW:0]   div_r;

  // index chain
  logic [BW-1:0]           idx_q [ibf_pkg::MAX_HASHES];
  logic [ibf_pkg::HW-1:0]  filled_q;
  logic [ibf_pkg::ITER_W-1:0] iter_q;
  logic [HSEL_W_L-1:0]     ap_j_q;
  logic                    dup;
  logic                    hit;

  // scan, clear, totals
  logic [BW-1:0] scan_q;
  logic [BW-1:0] clr_q;
  logic          empty_q;
  logic [ibf_pkg::TOT_W-1:0] rtot_q, ltot_q;

  // memory
  ibf_pkg::bucket_t mem [ibf_pkg::MAX_BUCKETS];
  ibf_pkg::bucket_t rd_q;
  ibf_pkg::bucket_t wd;
  logic [BW-1:0]    rd_addr, wr_addr;
  logic             we;

  // output registers
  logic done_q;
  ibf_pkg::status_e status_q;
  logic signed [1:0] side_q;
  logic [ibf_pkg::KEY_W-1:0] dkey_q;
  logic [ibf_pkg::TOT_W-1:0] rout_q, lout_q;

  logic signed [CB-1:0] rc_ext;
  logic [CB-1:0] rc_neg;

  assign crc_next = ibf_pkg::crc_byte(crc_q, src_q[7:0]);
  assign div_t = {rem_q, div_b_q[31]};
  assign div_r = (div_t >= (SW+1)'(size_eff)) ? div_t - (SW+1)'(size_eff) : div_t;

  // duplicate and hit checks over the filled indices
  always_comb begin
    dup = 1'b0;
    hit = 1'b0;
    for (int k = 0; k < ibf_pkg::MAX_HASHES; k++) begin
      if (ibf_pkg::HW'(k) < filled_q) begin
        if (idx_q[k] == rem_q[BW-1:0]) dup = 1'b1;
        if (idx_q[k] == scan_q) hit = 1'b1;
      end
    end
  end

  assign rc_ext = CB'(remote_count_i);
  assign rc_neg = CB'(-rc_ext);

  // status to controller
  always_comb begin
    sts_o.clr_last   = (32'(clr_q) == 32'(ibf_pkg::MAX_BUCKETS - 1));
    sts_o.crc_last   = crc_short_q ? (crc_cnt_q == 3'd3) : (crc_cnt_q == 3'd7);
    sts_o.div_last   = (div_cnt_q == 5'd31);
    sts_o.chain_done = ((filled_q + ibf_pkg::HW'(!dup)) == want) ||
                       (32'(iter_q) == 32'(ibf_pkg::ITER_LIMIT - 1));
    sts_o.want_zero  = (want == '0);
    sts_o.hash_match = (~crc_q == h_q);
    sts_o.hit        = hit;
    sts_o.ap_last    = ((ibf_pkg::HW'(ap_j_q) + ibf_pkg::HW'(1)) == filled_q);
    sts_o.cand       = (rd_q.cnt == CB'(1)) || (rd_q.cnt == {CB{1'b1}});
    sts_o.scan_last  = ((SW'(scan_q) + SW'(1)) == size_eff);
    sts_o.empty      = empty_q;
    sts_o.sub_ok     = (SW'(bucket_index_i) < size_eff);
  end

  // memory ports
  assign rd_addr = cmd_i.rd_scan ? scan_q : idx_q[ap_j_q];
  assign we      = cmd_i.clr_step || cmd_i.mem_wr;
  assign wr_addr = cmd_i.clr_step ? clr_q : idx_q[ap_j_q];
  always_comb begin
    wd.cnt  = rd_q.cnt + delta_q;
    wd.key  = rd_q.key ^ key_q;
    wd.hsum = rd_q.hsum ^ h_q;
    if (cmd_i.clr_step) wd = '0;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) rd_q <= mem[rd_addr];
  end

  // operands, CRC and modulo units, index list
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= key_i;
      src_q   <= key_i;
      h_q     <= remote_hash_sum_i;
      case (ibf_pkg::func_e'(func_i))
        ibf_pkg::F_INSERT: delta_q <= CB'(1);
        ibf_pkg::F_REMOVE: delta_q <= {CB{1'b1}};
        ibf_pkg::F_SUB:    delta_q <= rc_neg;
        default:           delta_q <= CB'(1);
      endcase
      idx_q[0] <= bucket_index_i[BW-1:0];
    end
    if (cmd_i.scan_take) begin
      key_q   <= rd_q.key;
      src_q   <= rd_q.key;
      h_q     <= rd_q.hsum;
      plus_q  <= (rd_q.cnt == CB'(1));
      delta_q <= (rd_q.cnt == CB'(1)) ? {CB{1'b1}} : CB'(1);
    end
    if (cmd_i.h_cap) h_q <= ~crc_q;
    if (cmd_i.chain_init) src_q <= key_q;
    if (cmd_i.crc_step) src_q <= src_q >> 8;
    if (cmd_i.div_start) begin
      div_b_q <= ~crc_next;
      rem_q   <= '0;
    end
    if (cmd_i.div_step) begin
      div_b_q <= div_b_q << 1;
      rem_q   <= div_r[SW-1:0];
    end
    if (cmd_i.idx_chk) begin
      if (!dup) idx_q[filled_q[HSEL_W_L-1:0]] <= rem_q[BW-1:0];
      src_q <= {~crc_q, 32'(iter_q)};
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= ibf_pkg::CRC_INIT;
      crc_cnt_q   <= '0;
      crc_short_q <= 1'b1;
      div_cnt_q   <= '0;
      filled_q    <= '0;
      iter_q      <= '0;
      ap_j_q      <= '0;
      scan_q      <= '0;
      clr_q       <= '0;
      empty_q     <= 1'b1;
      rtot_q      <= '0;
      ltot_q      <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + BW'(1);
      if (cmd_i.load || cmd_i.scan_take) begin
        crc_q       <= ibf_pkg::CRC_INIT;
        crc_cnt_q   <= '0;
        crc_short_q <= 1'b1;
      end
      if (cmd_i.load) begin
        filled_q <= (ibf_pkg::func_e'(func_i) == ibf_pkg::F_SUB) ? ibf_pkg::HW'(1) : '0;
        ap_j_q   <= '0;
        scan_q   <= '0;
        empty_q  <= 1'b1;
      end
      if (cmd_i.chain_init) begin
        crc_q       <= ibf_pkg::CRC_INIT;
        crc_cnt_q   <= '0;
        crc_short_q <= 1'b0;
        filled_q    <= '0;
        iter_q      <= '0;
        ap_j_q      <= '0;
      end
      if (cmd_i.crc_step) begin
        crc_q     <= crc_next;
        crc_cnt_q <= crc_cnt_q + 3'd1;
      end
      if (cmd_i.div_start) div_cnt_q <= '0;
      if (cmd_i.div_step) div_cnt_q <= div_cnt_q + 5'd1;
      if (cmd_i.idx_chk) begin
        filled_q  <= filled_q + ibf_pkg::HW'(!dup);
        iter_q    <= iter_q + ibf_pkg::ITER_W'(1);
        crc_q     <= ibf_pkg::CRC_INIT;
        crc_cnt_q <= '0;
      end
      if (cmd_i.ap_next) ap_j_q <= ap_j_q + HSEL_W_L'(1);
      if (cmd_i.scan_ev && (rd_q != '0)) empty_q <= 1'b0;
      if (cmd_i.scan_next) scan_q <= scan_q + BW'(1);
      if (cmd_i.tot_inc) begin
        if (plus_q) rtot_q <= rtot_q + 32'd1;
        else ltot_q <= ltot_q + 32'd1;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= cmd_i.out_fire;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_fire) begin
      status_q <= cmd_i.out_code;
      if (cmd_i.out_code == ibf_pkg::ST_DECODED) begin
        side_q <= plus_q ? 2'sb01 : 2'sb11;
        dkey_q <= key_q;
      end else begin
        side_q <= 2'sb00;
        dkey_q <= '0;
      end
      rout_q <= rtot_q;
      lout_q <= ltot_q;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign decoded_side_o   = side_q;
  assign decoded_key_o    = dkey_q;
  assign remote_decoded_o = rout_q;
  assign local_decoded_o  = lout_q;

  // checks
  a_clr_no_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !cmd_i.mem_wr) else $error("clear overlaps bucket write");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idx_chk |-> (rem_q < size_eff)) else $error("residue not below bucket count");
  a_filled_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= ibf_pkg::HW'(ibf_pkg::MAX_HASHES)) else $error("index list overflow");
  a_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == ibf_pkg::ST_DECODED)) |-> (side_q != 2'sb00))
    else $error("decoded result without side");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for invertible_bloom_filter_engine_unit.
// Depends on ibf_pkg for the operation and status codes; predicts each result and
// checks it against the result strobe, across several bucket and hash settings.
`timescale 1ns / 100ps

module tb_top;

  localparam int NBKT      = 1024;
  localparam int WDOG_MAX  = 2000000;

  // register byte addresses
  localparam logic [2:0] A_NUM_BUCKETS = 3'd0;
  localparam logic [2:0] A_HASH_COUNT  = 3'd4;

  typedef struct {
    ibf_pkg::func_e     op;
    logic [63:0]        key;
    logic [9:0]         bidx;
    logic signed [15:0] rcnt;
    logic [31:0]        rhash;
  } op_req_t;

  typedef struct packed {
    ibf_pkg::status_e   st;
    logic signed [1:0]  side;
    logic [63:0]        dkey;
    logic [31:0]        rtot;
    logic [31:0]        ltot;
  } op_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // APB port
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // command port
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func_i = '0;
  logic [63:0]        key_i = '0;
  logic [9:0]         bucket_index_i = '0;
  logic signed [15:0] remote_count_i = '0;
  logic [31:0]        remote_hash_sum_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [1:0]  decoded_side_o;
  logic [63:0]        decoded_key_o;
  logic [31:0]        remote_decoded_o, local_decoded_o;

  invertible_bloom_filter_engine_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .func_i, .key_i, .bucket_index_i, .remote_count_i,
    .remote_hash_sum_i, .done_o, .status_o, .decoded_side_o, .decoded_key_o,
    .remote_decoded_o, .local_decoded_o
  );

  // predictor state
  logic [15:0] cnt_mem  [NBKT];
  logic [63:0] ksum_mem [NBKT];
  logic [31:0] hsum_mem [NBKT];
  logic [31:0] rtot_q = '0, ltot_q = '0;
  logic [10:0] nb_reg = 11'd1024;
  logic [3:0]  hc_reg = 4'd3;
  int          idx_buf [ibf_pkg::MAX_HASHES];

  op_req_t pending_ops [$];
  op_rsp_t expected_rsp [$];
  op_req_t cur_op;
  int      idle_pct = 0;
  int      errors = 0, n_accepted = 0, n_results = 0, n_peeled = 0, n_undec = 0;
  int      quiet_cycles = 0;
  logic [63:0] key_pool [16];

  initial begin
    for (int i = 0; i < NBKT; i++) begin
      cnt_mem[i] = '0; ksum_mem[i] = '0; hsum_mem[i] = '0;
    end
  end

  // reflected CRC-32 over the low nbytes of v, little-endian
  function automatic logic [31:0] crc32_of(logic [63:0] v, int nbytes);
    logic [31:0] c;
    c = ibf_pkg::CRC_INIT;
    for (int b = 0; b < nbytes; b++) begin
      c ^= {24'd0, v[8*b +: 8]};
      for (int k = 0; k < 8; k++) c = (c >> 1) ^ (ibf_pkg::CRC_POLY & {32{c[0]}});
    end
    return ~c;
  endfunction

  function automatic int eff_size();
    if (nb_reg == 0) return 1;
    if (nb_reg > NBKT) return NBKT;
    return int'(nb_reg);
  endfunction

  function automatic int eff_hashes(int size);
    int h;
    h = int'(hc_reg);
    if (h > ibf_pkg::MAX_HASHES) h = ibf_pkg::MAX_HASHES;
    if (h > size) h = size;
    return h;
  endfunction

  // bucket index chain; fills idx_buf, returns number found
  function automatic int chain_indices(logic [63:0] key, int size, int want);
    int filled;
    int r;
    bit dup;
    logic [31:0] b;
    filled = 0;
    b = crc32_of(key, 8);
    for (int i = 0; filled < want && i < ibf_pkg::ITER_LIMIT; i++) begin
      r = int'(b % size);
      dup = 0;
      for (int j = 0; j < filled; j++) if (idx_buf[j] == r) dup = 1;
      if (!dup) begin
        idx_buf[filled] = r;
        filled++;
      end
      b = crc32_of({b, i[31:0]}, 8);
    end
    return filled;
  endfunction

  function automatic void fold_key(logic [63:0] key, int n, bit add);
    logic [31:0] h;
    h = crc32_of(key, 4);
    for (int i = 0; i < n; i++) begin
      cnt_mem[idx_buf[i]]  = add ? cnt_mem[idx_buf[i]] + 16'd1 : cnt_mem[idx_buf[i]] - 16'd1;
      ksum_mem[idx_buf[i]] ^= key;
      hsum_mem[idx_buf[i]] ^= h;
    end
  endfunction

  // updates the filter copy and returns the expected result
  function automatic op_rsp_t filter_result(op_req_t q);
    op_rsp_t r;
    int size, want, n;
    bit found, plus, hit, empty;
    size = eff_size();
    want = eff_hashes(size);
    r = '{ibf_pkg::ST_DONE, 2'sd0, 64'd0, 32'd0, 32'd0};
    case (q.op)
      ibf_pkg::F_INSERT, ibf_pkg::F_REMOVE: begin
        n = chain_indices(q.key, size, want);
        fold_key(q.key, n, q.op == ibf_pkg::F_INSERT);
      end
      ibf_pkg::F_SUB: begin
        if (q.bidx < size) begin
          cnt_mem[q.bidx]  = cnt_mem[q.bidx] - q.rcnt;
          ksum_mem[q.bidx] ^= q.key;
          hsum_mem[q.bidx] ^= q.rhash;
        end
      end
      default: begin
        found = 0;
        for (int i = 0; i < size; i++) begin
          plus = (cnt_mem[i] == 16'd1);
          if (!plus && cnt_mem[i] != 16'hFFFF) continue;
          if (crc32_of(ksum_mem[i], 4) != hsum_mem[i]) continue;
          n = chain_indices(ksum_mem[i], size, want);
          hit = 0;
          for (int j = 0; j < n; j++) if (idx_buf[j] == i) hit = 1;
          if (!hit) continue;
          found = 1;
          r.dkey = ksum_mem[i];
          if (plus) begin
            rtot_q++;
            r.side = 2'sd1;
          end else begin
            ltot_q++;
            r.side = -2'sd1;
          end
          fold_key(r.dkey, n, !plus);
          r.st = ibf_pkg::ST_DECODED;
          break;
        end
        if (!found) begin
          empty = 1;
          for (int i = 0; i < size; i++)
            if (cnt_mem[i] != 0 || hsum_mem[i] != 0 || ksum_mem[i] != 0) empty = 0;
          r.st = empty ? ibf_pkg::ST_EMPTY : ibf_pkg::ST_UNDEC;
        end
      end
    endcase
    r.rtot = rtot_q;
    r.ltot = ltot_q;
    return r;
  endfunction

  function automatic op_req_t mk_op(ibf_pkg::func_e op, logic [63:0] key);
    op_req_t q;
    q.op = op;
    q.key = key;
    q.bidx = 10'($urandom_range(1023));
    q.rcnt = 16'($urandom);
    q.rhash = $urandom;
    return q;
  endfunction

  // random transaction, mostly keys from a small pool so that removes and peels hit
  function automatic op_req_t rand_op();
    op_req_t q;
    int sel, size, n;
    logic [63:0] k;
    sel = $urandom_range(99);
    k = key_pool[$urandom_range(15)];
    if (sel < 38) q = mk_op(ibf_pkg::F_INSERT, k);
    else if (sel < 52) q = mk_op(ibf_pkg::F_REMOVE, k);
    else if (sel < 58) q = mk_op(sel < 55 ? ibf_pkg::F_INSERT : ibf_pkg::F_REMOVE,
                                 {$urandom, $urandom});
    else if (sel < 66) begin
      // remote bucket that holds exactly one pool key
      q = mk_op(ibf_pkg::F_SUB, k);
      q.rcnt = $urandom_range(1) ? 16'sd1 : -16'sd1;
      q.rhash = crc32_of(k, 4);
      size = eff_size();
      n = chain_indices(k, size, eff_hashes(size));
      q.bidx = (n > 0) ? 10'(idx_buf[$urandom_range(n - 1)]) : 10'd0;
    end else if (sel < 72) q = mk_op(ibf_pkg::F_SUB, {$urandom, $urandom});
    else q = mk_op(ibf_pkg::F_DECODE, {$urandom, $urandom});
    return q;
  endfunction

  // clock and reset
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: takes a transaction when start and not busy, then offers the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsp.push_back(filter_result(cur_op));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_op = pending_ops.pop_front();
          start             <= 1'b1;
          func_i            <= cur_op.op;
          key_i             <= cur_op.key;
          bucket_index_i    <= cur_op.bidx;
          remote_count_i    <= cur_op.rcnt;
          remote_hash_sum_i <= cur_op.rhash;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe must match the oldest expected result
  always @(posedge clk_i) begin
    op_rsp_t got, want;
    if (rst_ni && done_o) begin
      got = '{ibf_pkg::status_e'(status_o), decoded_side_o, decoded_key_o,
              remote_decoded_o, local_decoded_o};
      n_results++;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d key=%h", $time, got.st, got.dkey);
      end else begin
        want = expected_rsp.pop_front();
        if (want.st == ibf_pkg::ST_DECODED) n_peeled++;
        if (want.st == ibf_pkg::ST_UNDEC) n_undec++;
        if (got != want) begin
          errors++;
          $display("%0t: mismatch exp st=%0d side=%0d key=%h rt=%0d lt=%0d",
                   $time, want.st, want.side, want.dkey, want.rtot, want.ltot);
          $display("%0t:          got st=%0d side=%0d key=%h rt=%0d lt=%0d",
                   $time, got.st, got.side, got.dkey, got.rtot, got.ltot);
        end
      end
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == A_NUM_BUCKETS) nb_reg = data[10:0];
    else hc_reg = data[3:0];
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || start || expected_rsp.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(int nb, int hc, int idle, int count);
    reg_write(A_NUM_BUCKETS, 32'(nb));
    reg_write(A_HASH_COUNT, 32'(hc));
    idle_pct = idle;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < count; i++) pending_ops.push_back(rand_op());
    drain();
  endtask

  // stimulus
  initial begin
    op_req_t q;
    wait (rst_ni);
    // directed: empty filter, key extremes, both peel sides, subtract extremes
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    pending_ops.push_back(mk_op(ibf_pkg::F_INSERT, 64'd0));
    pending_ops.push_back(mk_op(ibf_pkg::F_INSERT, '1));
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '1));
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    pending_ops.push_back(mk_op(ibf_pkg::F_REMOVE, 64'h0123_4567_89AB_CDEF));
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    q = mk_op(ibf_pkg::F_SUB, '1); q.bidx = 10'd1023; q.rcnt = 16'sh8000; q.rhash = '1;
    pending_ops.push_back(q);
    q = mk_op(ibf_pkg::F_SUB, '0); q.bidx = 10'd0; q.rcnt = 16'sd32767; q.rhash = '0;
    pending_ops.push_back(q);
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    q = mk_op(ibf_pkg::F_SUB, '1); q.bidx = 10'd1023; q.rcnt = 16'sh8000; q.rhash = '1;
    pending_ops.push_back(q);
    q = mk_op(ibf_pkg::F_SUB, '0); q.bidx = 10'd0; q.rcnt = 16'sd32767; q.rhash = '0;
    pending_ops.push_back(q);
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    drain();
    // out-of-range subtract index with a small filter
    reg_write(A_NUM_BUCKETS, 32'd16);
    q = mk_op(ibf_pkg::F_SUB, '1); q.bidx = 10'd16; pending_ops.push_back(q);
    q = mk_op(ibf_pkg::F_SUB, '1); q.bidx = 10'd1023; pending_ops.push_back(q);
    pending_ops.push_back(mk_op(ibf_pkg::F_DECODE, '0));
    drain();

    // random phases across bucket/hash settings and sender idling
    run_phase(16,   3,  0,  300);
    run_phase(64,   4,  55, 300);
    run_phase(1,    8,  7,  150);
    run_phase(0,    15, 55, 100);
    run_phase(8,    8,  0,  250);
    run_phase(2047, 0,  7,  100);
    run_phase(1024, 8,  55, 150);
    run_phase(37,   2,  7,  400);

    $display("Covered %0d transactions, %0d results: %0d peeled, %0d undecodable",
             n_accepted, n_results, n_peeled, n_undec);
    $display("Bucket counts 0..2047 and hash counts 0..15 with sender idling 0/7/55%%");
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ibf_pkg.sv
rtl/core/ibf_ctrl.sv
rtl/core/ibf_dp.sv
rtl/core/invertible_bloom_filter_engine_unit.sv
dv/tb_top.sv
